// ===== design/hsl2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hsl2rgb_pkg
// Shared widths, codes, control-word layout and the microcode ROM of the
// HSL to RGB LED level converter.
// ----------------------------------------------------------------------------
package hsl2rgb_pkg;

   localparam int LVL_W         = 12;
   localparam int VAL_W         = 16;
   localparam int ACT_W         = 2;
   localparam int RSP_W         = 40;
   localparam int FRAC_BITS     = 16;
   localparam int FX_W          = 28;
   localparam int PROD_W        = 2 * FX_W;
   localparam int DIV_NUM_W     = 48;
   localparam int DIV_STEP_BITS = 8;
   localparam int DIV_STEPS     = DIV_NUM_W / DIV_STEP_BITS;
   localparam int DIV_CNT_W     = $clog2(DIV_STEPS + 1);
   localparam int REM_W         = LVL_W;

   typedef logic [LVL_W-1:0] level_type;

   // action codes (tuser of the request channel)
   localparam logic [ACT_W-1:0] ACT_HUE = 2'd0;
   localparam logic [ACT_W-1:0] ACT_SAT = 2'd1;
   localparam logic [ACT_W-1:0] ACT_LUM = 2'd2;

   // luminance values remapped on store
   localparam level_type LUM_ODD_A = 12'd759;
   localparam level_type LUM_FIX_A = 12'd758;
   localparam level_type LUM_ODD_B = 12'd1175;
   localparam level_type LUM_ODD_C = 12'd1176;
   localparam level_type LUM_FIX_B = 12'd1174;

   // sequencer step addresses
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] S_IDLE     = 4'd0;
   localparam logic [STEP_W-1:0] S_QMUL     = 4'd1;
   localparam logic [STEP_W-1:0] S_QDIV     = 4'd2;
   localparam logic [STEP_W-1:0] S_QWAIT    = 4'd3;
   localparam logic [STEP_W-1:0] S_FORM_Q   = 4'd4;
   localparam logic [STEP_W-1:0] S_FORM_PD  = 4'd5;
   localparam logic [STEP_W-1:0] S_CH_T     = 4'd6;
   localparam logic [STEP_W-1:0] S_CH_REG   = 4'd7;
   localparam logic [STEP_W-1:0] S_CH_MUL   = 4'd8;
   localparam logic [STEP_W-1:0] S_CH_DIV   = 4'd9;
   localparam logic [STEP_W-1:0] S_CH_WAIT  = 4'd10;
   localparam logic [STEP_W-1:0] S_CH_STORE = 4'd11;
   localparam logic [STEP_W-1:0] S_DONE     = 4'd12;
   localparam logic [STEP_W-1:0] S_GREY     = 4'd13;

   // datapath operations
   localparam logic [2:0] OP_NONE    = 3'd0;
   localparam logic [2:0] OP_FORM_Q  = 3'd1;
   localparam logic [2:0] OP_FORM_PD = 3'd2;
   localparam logic [2:0] OP_CH_T    = 3'd3;
   localparam logic [2:0] OP_CH_REG  = 3'd4;
   localparam logic [2:0] OP_STORE   = 3'd5;
   localparam logic [2:0] OP_GREY    = 3'd6;
   localparam logic [2:0] OP_OUT     = 3'd7;

   // multiplier operand select
   localparam logic [1:0] MUL_NONE = 2'd0;
   localparam logic [1:0] MUL_Q    = 2'd1;
   localparam logic [1:0] MUL_CH   = 2'd2;

   // divider numerator select
   localparam logic DSRC_Q  = 1'b0;
   localparam logic DSRC_CH = 1'b1;

   // jump conditions
   localparam logic [2:0] COND_NEVER    = 3'd0;
   localparam logic [2:0] COND_NO_REQ   = 3'd1;
   localparam logic [2:0] COND_SAT_ZERO = 3'd2;
   localparam logic [2:0] COND_DIV_BUSY = 3'd3;
   localparam logic [2:0] COND_FLAT     = 3'd4;
   localparam logic [2:0] COND_MORE_CH  = 3'd5;
   localparam logic [2:0] COND_OUT_BUSY = 3'd6;
   localparam logic [2:0] COND_ALWAYS   = 3'd7;

   // hue regions of one channel
   localparam logic [1:0] REG_RISE = 2'd0;
   localparam logic [1:0] REG_Q    = 2'd1;
   localparam logic [1:0] REG_FALL = 2'd2;
   localparam logic [1:0] REG_P    = 2'd3;

   // channel index
   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   typedef struct packed {
      logic              accept;
      logic [2:0]        op;
      logic [1:0]        mul;
      logic              div_go;
      logic              div_src;
      logic [2:0]        cond;
      logic [STEP_W-1:0] target;
      logic              to_idle;
   } ucode_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] numer;
   } div_req_type;

   typedef struct packed {
      logic                 busy;
      logic [DIV_NUM_W-1:0] quot;
   } div_rsp_type;

   // Microcode: if cond holds, go to target; else to_idle ? idle : next step.
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] addr);
      ucode_type w;
      w = '{accept: 1'b0, op: OP_NONE, mul: MUL_NONE, div_go: 1'b0,
            div_src: DSRC_Q, cond: COND_NEVER, target: S_IDLE, to_idle: 1'b0};
      case (addr)
         S_IDLE: begin
            w.accept = 1'b1;
            w.cond   = COND_NO_REQ;
            w.target = S_IDLE;
         end
         S_QMUL: begin
            w.mul    = MUL_Q;
            w.cond   = COND_SAT_ZERO;
            w.target = S_GREY;
         end
         S_QDIV: begin
            w.div_go  = 1'b1;
            w.div_src = DSRC_Q;
         end
         S_QWAIT: begin
            w.cond   = COND_DIV_BUSY;
            w.target = S_QWAIT;
         end
         S_FORM_Q:  w.op = OP_FORM_Q;
         S_FORM_PD: w.op = OP_FORM_PD;
         S_CH_T:    w.op = OP_CH_T;
         S_CH_REG:  w.op = OP_CH_REG;
         S_CH_MUL: begin
            w.mul    = MUL_CH;
            w.cond   = COND_FLAT;
            w.target = S_CH_STORE;
         end
         S_CH_DIV: begin
            w.div_go  = 1'b1;
            w.div_src = DSRC_CH;
         end
         S_CH_WAIT: begin
            w.cond   = COND_DIV_BUSY;
            w.target = S_CH_WAIT;
         end
         S_CH_STORE: begin
            w.op     = OP_STORE;
            w.cond   = COND_MORE_CH;
            w.target = S_CH_T;
         end
         S_DONE: begin
            w.op      = OP_OUT;
            w.cond    = COND_OUT_BUSY;
            w.target  = S_DONE;
            w.to_idle = 1'b1;
         end
         S_GREY: begin
            w.op     = OP_GREY;
            w.cond   = COND_ALWAYS;
            w.target = S_DONE;
         end
         default: w.to_idle = 1'b1;
      endcase
      return w;
   endfunction

endpackage

// ===== design/hsl2rgb_div.sv =====
// ----------------------------------------------------------------------------
// hsl2rgb_div
// Unsigned long division by a constant divisor, DIV_STEP_BITS quotient bits
// per cycle, restoring compare-subtract.
// ----------------------------------------------------------------------------
module hsl2rgb_div
   import hsl2rgb_pkg::*;
#(
   parameter int DIVISOR = 4000
)(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam logic [REM_W:0] DIV_D = (REM_W + 1)'(DIVISOR);

   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] acc_ff, acc_in;   // numerator out at top, quotient in at bottom
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] acc_v;
   logic [REM_W-1:0]     rem_v;
   logic [REM_W:0]       trial_v;

   always_comb begin
      acc_v   = acc_ff;
      rem_v   = rem_ff;
      trial_v = '0;
      for (int k = 0; k < DIV_STEP_BITS; k++) begin
         trial_v = {rem_v, acc_v[DIV_NUM_W-1]};
         acc_v   = {acc_v[DIV_NUM_W-2:0], 1'b0};
         if (trial_v >= DIV_D) begin
            trial_v  = trial_v - DIV_D;
            acc_v[0] = 1'b1;
         end
         rem_v = trial_v[REM_W-1:0];
      end

      cnt_in = cnt_ff;
      acc_in = acc_ff;
      rem_in = rem_ff;
      if (req.start) begin
         cnt_in = DIV_CNT_W'(DIV_STEPS);
         acc_in = req.numer;
         rem_in = '0;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         acc_in = acc_v;
         rem_in = rem_v;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      rem_ff <= rem_in;
   end

   assign rsp.busy = (cnt_ff != '0);
   assign rsp.quot = acc_ff;

endmodule

// ===== design/hsl_to_rgb_led_levels_core.sv =====
// ----------------------------------------------------------------------------
// hsl_to_rgb_led_levels_core
// Keeps hue, saturation and luminance levels and returns red, green and blue
// LED drive levels on the same 0..FULL_SCALE scale after every request beat.
// ----------------------------------------------------------------------------
// Sequence: zero saturation goes straight to the grey result; else q and p
//   are formed first, then each channel on a hue slope takes a multiply and a
//   divide while a flat channel skips the divide, and the result is loaded last.
// Throughput: one beat at a time; the next request beat is taken the cycle
//   after the result is loaded. The constant divider sets the pace.
// Reset: synchronous, active high; clears all three levels to zero, the
//   sequencer to idle and the result valid flag.
// ----------------------------------------------------------------------------
module hsl_to_rgb_led_levels_core
   import hsl2rgb_pkg::*;
#(
   parameter int FULL_SCALE = 4000
)(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [VAL_W-1:0] req_tdata,   // [15:0] value
   input  logic [ACT_W-1:0] req_tuser,   // [1:0] action
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // [11:0] red, [23:12] green, [35:24] blue
);

   // fixed-point unit: FULL_SCALE with 16 fraction bits
   localparam int UNIT_I  = FULL_SCALE * (2 ** FRAC_BITS);
   localparam int THIRD_I = UNIT_I / 3;
   localparam level_type                 FS_LVL  = LVL_W'(FULL_SCALE);
   localparam logic [FX_W-1:0]           UNIT    = FX_W'(UNIT_I);
   localparam logic signed [FX_W+1:0]    UNIT_S  = (FX_W + 2)'(UNIT_I);
   localparam logic signed [FX_W+1:0]    THIRD_S = (FX_W + 2)'(THIRD_I);

   // ---------------------------------------------------------------- sequencer
   logic [STEP_W-1:0] step_ff, step_in;
   ucode_type         uc;
   logic              jump;
   logic              out_busy;
   div_req_type       div_req;
   div_rsp_type       div_rsp;

   // stored levels
   level_type hue_ff, hue_in, sat_ff, sat_in, lum_ff, lum_in;
   level_type val_sat, val_lum;

   // datapath registers
   logic [FX_W-1:0]   q_ff, q_in, p_ff, p_in, d_ff, d_in;
   logic [FX_W-1:0]   t_ff, t_in, b_ff, b_in;
   logic [1:0]        region_ff, region_in;
   logic [1:0]        ch_ff, ch_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   level_type         red_ff, red_in, green_ff, green_in, blue_ff, blue_in;

   // result register
   logic      rsp_valid_ff, rsp_valid_in;
   level_type rsp_red_ff, rsp_red_in, rsp_green_ff, rsp_green_in;
   level_type rsp_blue_ff, rsp_blue_in;

   // datapath helpers
   logic                    lum_low;
   logic [FX_W-1:0]         mul_a, mul_b, quot;
   logic [FX_W:0]           lsum_fx, l2_fx;
   logic signed [FX_W+1:0]  ch_off, t_sum, t_wrap;
   logic [FX_W+2:0]         t6;
   logic [FX_W:0]           t2;
   logic [FX_W+1:0]         t3, u2, fall_d;
   logic [FX_W-1:0]         ch_val;

   assign uc         = ucode_rom(step_ff);
   assign req_tready = uc.accept;
   assign out_busy   = rsp_valid_ff && !rsp_tready;

   always_comb begin
      case (uc.cond)
         COND_NO_REQ:   jump = !req_tvalid;
         COND_SAT_ZERO: jump = (sat_ff == '0);
         COND_DIV_BUSY: jump = div_rsp.busy;
         COND_FLAT:     jump = (region_ff == REG_Q) || (region_ff == REG_P);
         COND_MORE_CH:  jump = (ch_ff != CH_BLUE);
         COND_OUT_BUSY: jump = out_busy;
         COND_ALWAYS:   jump = 1'b1;
         default:       jump = 1'b0;
      endcase
      if (jump) begin
         step_in = uc.target;
      end else if (uc.to_idle) begin
         step_in = S_IDLE;
      end else begin
         step_in = step_ff + 1'b1;
      end
   end

   // ------------------------------------------------------------ level update
   // Values saturate at full scale; luminance then remaps its odd values.
   assign val_sat = (req_tdata > VAL_W'(FULL_SCALE)) ? FS_LVL : req_tdata[LVL_W-1:0];

   always_comb begin
      if (val_sat == LUM_ODD_A) begin
         val_lum = LUM_FIX_A;
      end else if (val_sat inside {LUM_ODD_B, LUM_ODD_C}) begin
         val_lum = LUM_FIX_B;
      end else begin
         val_lum = val_sat;
      end
   end

   always_comb begin
      hue_in = hue_ff;
      sat_in = sat_ff;
      lum_in = lum_ff;
      if (req_tvalid && req_tready) begin
         case (req_tuser)
            ACT_HUE: hue_in = val_sat;
            ACT_SAT: sat_in = val_sat;
            ACT_LUM: lum_in = val_lum;
            default: begin
            end
         endcase
      end
   end

   // -------------------------------------------------------------- multiplier
   // 2L < FULL_SCALE: q = L*(F+S)/F; otherwise q = L + S - L*S/F (all << 16)
   assign lum_low = ({1'b0, lum_ff} << 1) < (LVL_W + 1)'(FULL_SCALE);

   always_comb begin
      case (uc.mul)
         MUL_Q: begin
            mul_a = FX_W'(lum_ff);
            mul_b = lum_low ? FX_W'({1'b0, FS_LVL} + {1'b0, sat_ff}) : FX_W'(sat_ff);
         end
         MUL_CH: begin
            mul_a = d_ff;
            mul_b = b_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = (uc.mul == MUL_NONE) ? prod_ff : PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   // ----------------------------------------------------------------- divider
   // Divide by U = F << 16: q path scales the product up by 16 bits before
   // dividing by F, channel path drops its 16 low bits first.
   assign div_req.start = uc.div_go;
   assign div_req.numer = (uc.div_src == DSRC_Q) ?
                          {prod_ff[DIV_NUM_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}} :
                          DIV_NUM_W'(prod_ff[PROD_W-1:FRAC_BITS]);
   assign quot = div_rsp.quot[FX_W-1:0];

   hsl2rgb_div #(
      .DIVISOR (FULL_SCALE)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // ---------------------------------------------------------------- datapath
   assign lsum_fx = {({1'b0, lum_ff} + {1'b0, sat_ff}), {FRAC_BITS{1'b0}}};
   assign l2_fx   = {lum_ff, {(FRAC_BITS + 1){1'b0}}};

   // hue position, red leads by a third, blue lags by a third; wrap once
   always_comb begin
      case (ch_ff)
         CH_RED:   ch_off = THIRD_S;
         CH_GREEN: ch_off = '0;
         default:  ch_off = -THIRD_S;
      endcase
      t_sum = $signed({2'b00, hue_ff, {FRAC_BITS{1'b0}}}) + ch_off;
      if (t_sum < 0) begin
         t_wrap = t_sum + UNIT_S;
      end else if (t_sum > UNIT_S) begin
         t_wrap = t_sum - UNIT_S;
      end else begin
         t_wrap = t_sum;
      end
   end

   assign t6     = {1'b0, t_ff, 2'b00} + {2'b00, t_ff, 1'b0};
   assign t2     = {t_ff, 1'b0};
   assign t3     = {1'b0, t_ff, 1'b0} + {2'b00, t_ff};
   assign u2     = {1'b0, UNIT, 1'b0};
   assign fall_d = u2 - t3;

   assign ch_val = ((region_ff == REG_RISE) || (region_ff == REG_FALL)) ? p_ff + quot :
                   (region_ff == REG_Q) ? q_ff : p_ff;

   always_comb begin
      q_in         = q_ff;
      p_in         = p_ff;
      d_in         = d_ff;
      t_in         = t_ff;
      b_in         = b_ff;
      region_in    = region_ff;
      ch_in        = ch_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      rsp_red_in   = rsp_red_ff;
      rsp_green_in = rsp_green_ff;
      rsp_blue_in  = rsp_blue_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (uc.op)
         OP_FORM_Q: begin
            q_in = lum_low ? quot : FX_W'(lsum_fx - {1'b0, quot});
         end
         OP_FORM_PD: begin
            p_in  = FX_W'(l2_fx - {1'b0, q_ff});
            d_in  = FX_W'({q_ff, 1'b0} - l2_fx);
            ch_in = CH_RED;
         end
         OP_CH_T: begin
            t_in = FX_W'(t_wrap);
         end
         OP_CH_REG: begin
            if (t6 < {3'b000, UNIT}) begin
               region_in = REG_RISE;
               b_in      = FX_W'(t6);
            end else if (t2 < {1'b0, UNIT}) begin
               region_in = REG_Q;
            end else if (t3 < u2) begin
               region_in = REG_FALL;
               b_in      = FX_W'({fall_d, 1'b0});
            end else begin
               region_in = REG_P;
            end
         end
         OP_STORE: begin
            case (ch_ff)
               CH_RED:   red_in   = ch_val[FX_W-1:FRAC_BITS];
               CH_GREEN: green_in = ch_val[FX_W-1:FRAC_BITS];
               default:  blue_in  = ch_val[FX_W-1:FRAC_BITS];
            endcase
            if (ch_ff != CH_BLUE) begin
               ch_in = ch_ff + 1'b1;
            end
         end
         OP_GREY: begin
            red_in   = lum_ff;
            green_in = lum_ff;
            blue_in  = lum_ff;
         end
         OP_OUT: begin
            if (!out_busy) begin
               rsp_valid_in = 1'b1;
               rsp_red_in   = red_ff;
               rsp_green_in = green_ff;
               rsp_blue_in  = blue_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // --------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= S_IDLE;
         hue_ff       <= '0;
         sat_ff       <= '0;
         lum_ff       <= '0;
         ch_ff        <= CH_RED;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         hue_ff       <= hue_in;
         sat_ff       <= sat_in;
         lum_ff       <= lum_in;
         ch_ff        <= ch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff         <= q_in;
      p_ff         <= p_in;
      d_ff         <= d_in;
      t_ff         <= t_in;
      b_ff         <= b_in;
      region_ff    <= region_in;
      prod_ff      <= prod_in;
      red_ff       <= red_in;
      green_ff     <= green_in;
      blue_ff      <= blue_in;
      rsp_red_ff   <= rsp_red_in;
      rsp_green_ff <= rsp_green_in;
      rsp_blue_ff  <= rsp_blue_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W - 3 * LVL_W){1'b0}}, rsp_blue_ff, rsp_green_ff, rsp_red_ff};

   // -------------------------------------------------------------- assertions
   // divider is only launched when idle
   a_div_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      uc.div_go |-> !div_rsp.busy)
      else $error("divider started while busy");

   // stored levels never exceed full scale
   a_levels_in_range: assert property (@(posedge clock) disable iff (reset)
      (hue_ff <= FS_LVL) && (sat_ff <= FS_LVL) && (lum_ff <= FS_LVL))
      else $error("stored level above full scale");

   // delivered drive levels stay on scale
   a_result_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_red_ff <= FS_LVL) && (rsp_green_ff <= FS_LVL) &&
                       (rsp_blue_ff <= FS_LVL))
      else $error("result level above full scale");

   // an accepted beat starts the conversion program
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (step_ff == S_QMUL))
      else $error("request beat did not start conversion");

endmodule

// ===== dv/hsl_to_rgb_led_levels_core_tb.sv =====
// ----------------------------------------------------------------------------
// hsl_to_rgb_led_levels_core_tb
// Self-checking bench for the HSL to RGB LED level converter. Request beats
// set hue, saturation or luminance. A scoreboard predicts every result from
// its own copy of the three levels, using fixed-point math, and compares the
// red, green and blue fields of each result beat in order. Both sides of the
// stream stall at random, and the amount of stalling changes between phases.
// ----------------------------------------------------------------------------
module hsl_to_rgb_led_levels_core_tb;
   import hsl2rgb_pkg::*;

   localparam int FULL_SCALE   = 4000;
   localparam int RESET_CYCLES = 5;
   localparam int PHASE_BEATS  = 500;      // three phases of random traffic
   localparam int DRAIN_CYCLES = 60;       // wait after the last result is checked
   localparam int CYCLE_LIMIT  = 1000000;  // well over 10x the slowest clean run

   // Action code 3 has no meaning in the block: the levels stay as they are,
   // but a result still comes back.
   localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

   typedef longint unsigned fx_word_type;  // level * 2^16 fixed point

   // packed from the top down, so red lands in the low bits like rsp_tdata
   typedef struct packed {
      level_type blue;
      level_type green;
      level_type red;
   } rgb_levels_type;

   // -------------------------------------------------------------------------
   // Scoreboard: holds the level state, predicts each result and checks it
   // -------------------------------------------------------------------------
   class led_level_board;
      level_type      hue_now, sat_now, lum_now;
      rgb_levels_type owed[$];
      int             mismatches, checked, grey_seen;
      int             beats_by_action[4];

      function new();
         hue_now    = '0;
         sat_now    = '0;
         lum_now    = '0;
         mismatches = 0;
         checked    = 0;
         grey_seen  = 0;
         foreach (beats_by_action[i]) beats_by_action[i] = 0;
      endfunction

      // One channel: t is the hue position, wrapped once into 0..unit.
      function level_type channel_level(fx_word_type p, fx_word_type q, longint t,
                                        fx_word_type unit);
         longint      span;
         fx_word_type ut, d, lvl;
         span = longint'(unit);
         d    = q - p;
         if (t < 0)
            t += span;
         if (t > span)
            t -= span;
         ut = fx_word_type'(t);
         if (6 * ut < unit)
            lvl = p + (d * 6 * ut) / unit;          // rising slope
         else if (2 * ut < unit)
            lvl = q;
         else if (3 * ut < 2 * unit)
            lvl = p + (d * 2 * (2 * unit - 3 * ut)) / unit;   // falling slope
         else
            lvl = p;
         return level_type'(lvl >> FRAC_BITS);
      endfunction

      function rgb_levels_type hsl_levels();
         fx_word_type    unit, h, s, l, third, p, q;
         rgb_levels_type c;
         if (sat_now == '0) begin
            c.red   = lum_now;
            c.green = lum_now;
            c.blue  = lum_now;
            return c;
         end
         unit  = fx_word_type'(FULL_SCALE) << FRAC_BITS;
         h     = fx_word_type'(hue_now) << FRAC_BITS;
         s     = fx_word_type'(sat_now) << FRAC_BITS;
         l     = fx_word_type'(lum_now) << FRAC_BITS;
         third = unit / 3;
         if (2 * l < unit)
            q = (l * (unit + s)) / unit;
         else
            q = l + s - (l * s) / unit;
         p = 2 * l - q;
         c.red   = channel_level(p, q, longint'(h) + longint'(third), unit);
         c.green = channel_level(p, q, longint'(h), unit);
         c.blue  = channel_level(p, q, longint'(h) - longint'(third), unit);
         return c;
      endfunction

      // Accepted request beat: update the levels, queue the result it owes.
      function void note_request(logic [ACT_W-1:0] act, logic [VAL_W-1:0] val);
         level_type v;
         v = (val > FULL_SCALE) ? level_type'(FULL_SCALE) : val[LVL_W-1:0];
         beats_by_action[act]++;
         case (act)
            ACT_HUE: hue_now = v;
            ACT_SAT: sat_now = v;
            ACT_LUM: begin
               if (v == LUM_ODD_A)
                  lum_now = LUM_FIX_A;
               else if (v == LUM_ODD_B || v == LUM_ODD_C)
                  lum_now = LUM_FIX_B;
               else
                  lum_now = v;
            end
            default: ;
         endcase
         if (sat_now == '0)
            grey_seen++;
         owed.push_back(hsl_levels());
      endfunction

      task flag(string what, longint got, longint want);
         mismatches++;
         if (mismatches <= 100)
            $display("MISMATCH @%0t %s: got %0d, want %0d", $time, what, got, want);
      endtask

      function int outstanding();
         return owed.size();
      endfunction

      task check_levels(logic [RSP_W-1:0] beat);
         rgb_levels_type want;
         rgb_levels_type got;
         got = beat[3*LVL_W-1:0];
         if (owed.size() == 0) begin
            flag("result beat with nothing outstanding", got, 0);
         end else begin
            want = owed.pop_front();
            checked++;
            if (got.red !== want.red)
               flag("red", got.red, want.red);
            if (got.green !== want.green)
               flag("green", got.green, want.green);
            if (got.blue !== want.blue)
               flag("blue", got.blue, want.blue);
         end
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and DUT
   // -------------------------------------------------------------------------
   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [VAL_W-1:0] req_tdata  = '0;   // [15:0] value
   logic [ACT_W-1:0] req_tuser  = '0;   // [1:0] action
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;         // [11:0] red, [23:12] green, [35:24] blue

   led_level_board board;
   int             req_idle_pct = 0;    // chance in 100 that the sender idles a cycle
   int             rsp_idle_pct = 0;    // chance in 100 that the receiver stalls a cycle
   int             cycle_count  = 0;

   always #2 clock = ~clock;

   hsl_to_rgb_led_levels_core #(
      .FULL_SCALE (FULL_SCALE)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // -------------------------------------------------------------------------
   // Result side: check a beat on handshake, then pick next cycle's ready.
   // Outputs are read at the edge before any NBA of that edge lands.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_levels(rsp_tdata);
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, board.outstanding());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Request side. Called at a rising edge; returns at the edge that took the
   // beat with tvalid still high, so back-to-back beats drop tvalid only when the sender idles.
   // -------------------------------------------------------------------------
   task automatic send_beat(input logic [ACT_W-1:0] act, input logic [VAL_W-1:0] val);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= val;
      req_tuser  <= act;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      board.note_request(act, val);
   endtask

   // Values lean toward the legal range, with clamps, remapped luminances,
   // hue region edges and zero saturation mixed in; full 16-bit noise too.
   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(9))
         0, 1: return VAL_W'($urandom_range(16'hFFFF));
         2: begin
            case ($urandom_range(7))
               0: return 16'd759;
               1: return 16'd1175;
               2: return 16'd1176;
               3: return 16'd4001;
               4: return VAL_W'(FULL_SCALE);
               5: return 16'd1333 + VAL_W'($urandom_range(1));
               6: return 16'd2666 + VAL_W'($urandom_range(1));
               default: return 16'd2000;
            endcase
         end
         3: return '0;
         default: return VAL_W'($urandom_range(FULL_SCALE));
      endcase
   endfunction

   function automatic logic [ACT_W-1:0] pick_action();
      if ($urandom_range(15) == 0)
         return ACT_NONE;
      return ACT_W'($urandom_range(2));
   endfunction

   task automatic random_phase(input int send_idle, input int recv_idle);
      req_idle_pct = send_idle;
      rsp_idle_pct = recv_idle;
      repeat (PHASE_BEATS)
         send_beat(pick_action(), pick_value());
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      board = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: grey path with luminance clamps and remaps first, then the
      // hue region edges at full saturation, then the q/p split on luminance.
      send_beat(ACT_NONE, 16'd0);
      send_beat(ACT_LUM, 16'hFFFF);
      send_beat(ACT_LUM, 16'd759);
      send_beat(ACT_LUM, 16'd1175);
      send_beat(ACT_LUM, 16'd1176);
      send_beat(ACT_LUM, 16'd4001);
      send_beat(ACT_SAT, 16'hFFFF);
      send_beat(ACT_HUE, 16'd0);
      send_beat(ACT_LUM, 16'd2000);
      send_beat(ACT_HUE, 16'd667);
      send_beat(ACT_HUE, 16'd1333);
      send_beat(ACT_HUE, 16'd1334);
      send_beat(ACT_HUE, 16'd2666);
      send_beat(ACT_HUE, 16'd2667);
      send_beat(ACT_HUE, 16'd4000);
      send_beat(ACT_HUE, 16'hFFFF);
      send_beat(ACT_SAT, 16'd1);
      send_beat(ACT_LUM, 16'd1999);
      send_beat(ACT_LUM, 16'd0);
      send_beat(ACT_LUM, 16'd4000);
      send_beat(ACT_SAT, 16'd2000);
      send_beat(ACT_LUM, 16'd1000);
      send_beat(ACT_NONE, 16'hFFFF);
      send_beat(ACT_SAT, 16'd0);

      // Random: slow receiver, then slow sender, then full rate.
      random_phase(34, 87);
      random_phase(87, 34);
      random_phase(0, 0);
      req_tvalid <= 1'b0;

      while (board.outstanding() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d hue, %0d saturation, %0d luminance, %0d unused-code beats",
               board.beats_by_action[ACT_HUE], board.beats_by_action[ACT_SAT],
               board.beats_by_action[ACT_LUM], board.beats_by_action[ACT_NONE]);
      $display("checked %0d results (%0d grey), %0d mismatches",
               board.checked, board.grey_seen, board.mismatches);
      if (board.mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== sim.f =====
design/hsl2rgb_pkg.sv
design/hsl2rgb_div.sv
design/hsl_to_rgb_led_levels_core.sv
dv/hsl_to_rgb_led_levels_core_tb.sv
